// ----- hdl/refraction_index_tracker_macros.svh -----
// Assertion macros used by the file that checks its own logic.
`ifndef REFRACTION_INDEX_TRACKER_MACROS_SVH
`define REFRACTION_INDEX_TRACKER_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define RIT_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RIT_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define RIT_ASSERT_IMP(lbl, ck, rstn, ante, cons)
`define RIT_ASSERT_NXT(lbl, ck, rstn, ante, cons)

`endif

`endif

// ----- hdl/rit_pkg.sv -----
package rit_pkg;

	// Refraction index of vacuum, 1.0 in unsigned Q4.12.
	localparam logic [15:0] ONE_Q12 = 16'd4096;

	// Depth of the queue between front and back, and its pointer width.
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;

	typedef struct packed {
		logic        first_of_ray;
		logic [15:0] obj_id;
		logic [15:0] refr_index;
		logic        is_hit;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic {
		ST_LOOKUP,
		ST_APPLY
	} back_state_t;

endpackage

// ----- hdl/refraction_index_tracker.sv -----
// Refraction index tracker. Feed it the intersections of one ray in sorted order, the first
// one flagged in s_tuser[0]; it keeps the list of shapes the ray is inside (up to MAX_NEST
// of them) and, at the item flagged as the hit in s_tuser[1], returns one result item with
// the index of the medium being left and of the medium being entered (1.0 when outside
// everything) and a flag telling whether an entry was lost to a full list. Items after the
// hit are swallowed until the next ray starts. Each item passes two steps in the list
// engine, a search of the list in the lookup state and a shift of it in the apply state,
// so it takes no new item before the last is through; the input side accepts an item per
// cycle into a two-entry queue until that fills. A hit result is offered once its item has
// passed the queue and both states, later when items wait ahead or an earlier result is held.

`include "refraction_index_tracker_macros.svh"

module refraction_index_tracker
	import rit_pkg::*;
#(
	parameter int MAX_NEST = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // obj_id [15:0], refr_index [31:16]
	input  logic [1:0]  s_tuser,  // first_of_ray [0], is_hit [1]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // n_from [15:0], n_to [31:16]
	output logic [0:0]  m_tuser   // list_overflow [0]
);

	// Handshake between the front, the queue and the list engine.
	logic    q_push;
	item_t   q_push_data;
	logic    q_pop;
	item_t   q_head;
	q_stat_t q_stat;

	// The front checks each item against the ray state and drops the ones after the hit.
	rit_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_stat    (q_stat),
		.push      (q_push),
		.push_data (q_push_data)
	);

	// The queue lets the front keep taking items while the engine is busy or stalled.
	rit_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	// The list engine searches and updates the container list and builds the result.
	rit_back #(
		.MAX_NEST (MAX_NEST)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.q_stat   (q_stat),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// The front must never write into a full queue.
	`RIT_ASSERT_IMP(a_no_push_full, clk, arst_n, q_push, !q_stat.full)
	// The engine must never take an item from an empty queue.
	`RIT_ASSERT_IMP(a_no_pop_empty, clk, arst_n, q_pop, !q_stat.empty)
	// A written item is still waiting or being taken in the following cycle.
	`RIT_ASSERT_NXT(a_push_visible, clk, arst_n, q_push, !q_stat.empty)

endmodule

// ----- hdl/rit_queue.sv -----
module rit_queue
	import rit_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   push_data,
	input  logic    pop,
	output item_t   head,
	output q_stat_t stat
);

	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	item_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == CNT_W'(Q_DEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule

// ----- hdl/rit_front.sv -----
module rit_front
	import rit_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  q_stat_t     q_stat,
	output logic        push,
	output item_t       push_data
);

	// High once the hit of the current ray has gone through.
	logic  ray_done_q;
	logic  accept;
	logic  keep;
	item_t item;

	assign item.first_of_ray = s_tuser[0];
	assign item.is_hit       = s_tuser[1];
	assign item.obj_id       = s_tdata[15:0];
	assign item.refr_index   = s_tdata[31:16];

	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;
	// Items after the hit are dropped here until a new ray starts.
	assign keep     = item.first_of_ray || !ray_done_q;

	assign push      = accept && keep;
	assign push_data = item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray_done_q <= 1'b0;
		end else if (push) begin
			ray_done_q <= item.is_hit;
		end
	end

endmodule

// ----- hdl/rit_back.sv -----
module rit_back
	import rit_pkg::*;
#(
	parameter int MAX_NEST = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       head,
	input  q_stat_t     q_stat,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic [0:0]  m_tuser
);

	localparam int CNT_W = $clog2(MAX_NEST + 1);
	localparam int POS_W = $clog2(MAX_NEST);

	// The list is kept newest first: entry 0 is the medium the ray is in.
	logic [15:0]      ids_q [MAX_NEST];
	logic [15:0]      idx_q [MAX_NEST];
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;

	back_state_t state_q;
	back_state_t state_nxt;

	item_t            item_s1;
	logic             found_s1;
	logic [POS_W-1:0] pos_s1;
	logic [CNT_W-1:0] cnt_s1;
	logic             ovf_s1;
	logic [15:0]      n_from_s1;

	logic             mvalid_q;
	logic [31:0]      mdata_q;
	logic             movf_q;

	logic             out_free;
	logic             apply_en;
	logic [CNT_W-1:0] eff_cnt;
	logic             found;
	logic [POS_W-1:0] pos;
	logic             full;
	logic             do_push;
	logic [CNT_W-1:0] new_cnt;
	logic             new_ovf;
	logic [15:0]      n_to;

	assign out_free = !mvalid_q || m_tready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_LOOKUP: begin
				if (!q_stat.empty) begin
					state_nxt = ST_APPLY;
				end
			end
			ST_APPLY: begin
				if (apply_en) begin
					state_nxt = ST_LOOKUP;
				end
			end
			default: state_nxt = ST_LOOKUP;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		apply_en = 1'b0;
		unique case (state_q)
			ST_LOOKUP: pop      = !q_stat.empty;
			ST_APPLY:  apply_en = !item_s1.is_hit || out_free;
			default: begin
				pop      = 1'b0;
				apply_en = 1'b0;
			end
		endcase
	end

	// Search from the newest entry towards the oldest; the oldest match wins.
	always_comb begin
		eff_cnt = head.first_of_ray ? '0 : count_q;
		found   = 1'b0;
		pos     = '0;
		for (int p = 0; p < MAX_NEST; p++) begin
			if ((CNT_W'(p) < eff_cnt) && (ids_q[p] == head.obj_id)) begin
				found = 1'b1;
				pos   = POS_W'(p);
			end
		end
	end

	always_comb begin
		full    = (cnt_s1 == CNT_W'(MAX_NEST));
		do_push = !found_s1 && !full;
		new_ovf = ovf_s1 || (!found_s1 && full);
		if (found_s1) begin
			new_cnt = cnt_s1 - 1'b1;
		end else if (do_push) begin
			new_cnt = cnt_s1 + 1'b1;
		end else begin
			new_cnt = cnt_s1;
		end
		if (do_push) begin
			n_to = item_s1.refr_index;
		end else if (!found_s1) begin
			n_to = idx_q[0];
		end else if (new_cnt == '0) begin
			n_to = ONE_Q12;
		end else if (pos_s1 == '0) begin
			n_to = idx_q[1];
		end else begin
			n_to = idx_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOOKUP;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			mvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (apply_en) begin
				count_q <= new_cnt;
				ovf_q   <= new_ovf;
			end
			if (apply_en && item_s1.is_hit) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1   <= head;
			found_s1  <= found;
			pos_s1    <= pos;
			cnt_s1    <= eff_cnt;
			ovf_s1    <= head.first_of_ray ? 1'b0 : ovf_q;
			n_from_s1 <= (eff_cnt == '0) ? ONE_Q12 : idx_q[0];
		end
		if (apply_en && item_s1.is_hit) begin
			mdata_q <= {n_to, n_from_s1};
			movf_q  <= new_ovf;
		end
		if (apply_en && found_s1) begin
			for (int p = 0; p < MAX_NEST - 1; p++) begin
				if (POS_W'(p) >= pos_s1) begin
					ids_q[p] <= ids_q[p+1];
					idx_q[p] <= idx_q[p+1];
				end
			end
		end else if (apply_en && do_push) begin
			for (int p = 1; p < MAX_NEST; p++) begin
				ids_q[p] <= ids_q[p-1];
				idx_q[p] <= idx_q[p-1];
			end
			ids_q[0] <= item_s1.obj_id;
			idx_q[0] <= item_s1.refr_index;
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = mdata_q;
	assign m_tuser  = movf_q;

endmodule
